[design/gradient_ramp_lookup_macros.svh]
// assertion macros shared by the checker
`ifndef GRADIENT_RAMP_LOOKUP_MACROS_SVH
`define GRADIENT_RAMP_LOOKUP_MACROS_SVH

// same-cycle implication
`define GRL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gradient ramp check failed");

// next-cycle implication
`define GRL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gradient ramp check failed");

`endif

[design/grl_pkg.sv]
package grl_pkg;

    localparam int RAMP_BITS_DEF  = 10;
    localparam int STOP_SLOTS_DEF = 12;

    localparam logic [16:0] POS_ONE = 17'h10000;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_OVERFLOW = 1'b1;

    localparam logic [1:0] MODE_PAD     = 2'd0;
    localparam logic [1:0] MODE_REFLECT = 2'd1;
    localparam logic [1:0] MODE_REPEAT  = 2'd2;

    localparam logic [1:0] REG_ADDR_MODE = 2'd0;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_STAT,
        ST_FETCH0,
        ST_PAD0,
        ST_SEG,
        ST_SEGCHK,
        ST_ADV,
        ST_TAIL,
        ST_DIVINIT,
        ST_DIV,
        ST_BLEND,
        ST_WRITE
    } state_t;

    function automatic logic [7:0] blend_channel(input logic [7:0] a, input logic [7:0] b,
                                                 input logic [7:0] w);
        logic [16:0] s;
        logic [16:0] t;
        s = 17'(a * (8'd255 - w)) + 17'(b * w);
        t = s + (s >> 8) + 17'd1;
        return t[15:8];
    endfunction

endpackage

[design/grl_ramp_mem.sv]
module grl_ramp_mem #(
    parameter int ADDR_BITS = grl_pkg::RAMP_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [31:0]          wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [31:0]          rdata
);

    logic [31:0] mem [2**ADDR_BITS];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/gradient_ramp_lookup.sv]
// channel   direction  transfer marker                  payload
// command   in         start && !busy                   operation, stop_position, stop_color,
//                                                       last_stop, sample_position
// result    out        done (one cycle)                 ramp_color, status
// config    in         psel && penable && pwrite        paddr, pwdata (gradient_mode at 0)
//
// lookup: one read of the ramp memory port; the registered read data is returned in ST_LOOK
// stop load without last mark: written while idle; last stop with too many stops: status from ST_STAT
// rebuild: per blended entry an 8-step divider, 4 channel blend steps and a write,
//   plus a write per padded entry, all through the single memory write port
// after reset all 2^RAMP_BITS ramp memory entries are swept to zero with busy high
// the receiver cannot stall; each result shows for exactly one cycle
module gradient_ramp_lookup #(
    parameter int RAMP_BITS  = grl_pkg::RAMP_BITS_DEF,
    parameter int STOP_SLOTS = grl_pkg::STOP_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        operation,
    input  logic [16:0] stop_position,
    input  logic [31:0] stop_color,
    input  logic        last_stop,
    input  logic signed [23:0] sample_position,
    output logic        done,
    output logic [31:0] ramp_color,
    output logic        status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int RB = RAMP_BITS;
    localparam int CW = $clog2(STOP_SLOTS);
    localparam logic [RB-1:0] RAMP_MAX = {RB{1'b1}};
    localparam logic [CW-1:0] FULL_AT  = CW'(STOP_SLOTS - 2);

    grl_pkg::state_t state_reg, state_next;

    logic [1:0]    mode_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          first_nz_reg, first_nz_next;
    logic          status_reg, status_next;
    logic [CW-1:0] c_reg, c_next;
    logic [RB-1:0] i_reg, i_next;
    logic [RB-1:0] cur_idx_reg, cur_idx_next;
    logic [31:0]   cur_col_reg, cur_col_next;
    logic [RB-1:0] nxt_idx_reg, nxt_idx_next;
    logic [31:0]   nxt_col_reg, nxt_col_next;
    logic [RB-1:0] diff_reg, diff_next;
    logic [RB+7:0] rem_reg, rem_next;
    logic [RB+7:0] dsh_reg, dsh_next;
    logic [7:0]    q_reg, q_next;
    logic [2:0]    bit_reg, bit_next;
    logic [1:0]    ch_reg, ch_next;
    logic [31:0]   blend_reg, blend_next;

    logic [RB-1:0] stop_idx_mem [STOP_SLOTS];
    logic [31:0]   stop_col_mem [STOP_SLOTS];

    logic          accept;
    logic          full;
    logic [16:0]   pos_sat;
    logic [RB+16:0] pos_prod;
    logic [RB-1:0] new_idx;
    logic          stop_we;
    logic [CW-1:0] fetch_sel;
    logic [RB-1:0] k;
    logic [7:0]    ch_res;

    logic          mem_we;
    logic [RB-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic [RB-1:0] mem_raddr;
    logic [31:0]   mem_rdata;

    logic [23:0]   mag;

    assign busy   = (state_reg != grl_pkg::ST_IDLE);
    assign accept = start && !busy;
    assign pready = 1'b1;
    assign prdata = (paddr == grl_pkg::REG_ADDR_MODE) ? {30'd0, mode_reg} : 32'd0;

    assign pos_sat  = (stop_position > grl_pkg::POS_ONE) ? grl_pkg::POS_ONE : stop_position;
    assign pos_prod = (RB+17)'(pos_sat) * (RB+17)'(RAMP_MAX);
    assign new_idx  = pos_prod[16 +: RB];
    assign full     = (count_reg >= FULL_AT);

    // lookup address
    assign mag = sample_position[23] ? (24'd0 - sample_position) : sample_position;

    always_comb
    begin
        case (mode_reg)
            grl_pkg::MODE_REFLECT:
            begin
                mem_raddr = mag[RB] ? ~mag[RB-1:0] : mag[RB-1:0];
            end
            grl_pkg::MODE_REPEAT:
            begin
                mem_raddr = sample_position[RB-1:0];
            end
            default:
            begin
                if (sample_position[23])
                begin
                    mem_raddr = '0;
                end
                else if (sample_position[22:0] > 23'(RAMP_MAX))
                begin
                    mem_raddr = RAMP_MAX;
                end
                else
                begin
                    mem_raddr = sample_position[RB-1:0];
                end
            end
        endcase
    end

    grl_ramp_mem #(
        .ADDR_BITS(RAMP_BITS)
    ) u_mem (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    assign k      = i_reg - cur_idx_reg;
    assign ch_res = grl_pkg::blend_channel(cur_col_reg[8*ch_reg +: 8],
                                           nxt_col_reg[8*ch_reg +: 8], q_reg);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        first_nz_next = first_nz_reg;
        status_next   = status_reg;
        c_next        = c_reg;
        i_next        = i_reg;
        cur_idx_next  = cur_idx_reg;
        cur_col_next  = cur_col_reg;
        nxt_idx_next  = nxt_idx_reg;
        nxt_col_next  = nxt_col_reg;
        diff_next     = diff_reg;
        rem_next      = rem_reg;
        dsh_next      = dsh_reg;
        q_next        = q_reg;
        bit_next      = bit_reg;
        ch_next       = ch_reg;
        blend_next    = blend_reg;
        stop_we       = 1'b0;
        fetch_sel     = c_reg + CW'(1);
        mem_we        = 1'b0;
        mem_waddr     = i_reg;
        mem_wdata     = cur_col_reg;
        done          = 1'b0;
        ramp_color    = 32'd0;
        status        = grl_pkg::STATUS_OK;

        case (state_reg)
            grl_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = 32'd0;
                if (i_reg == RAMP_MAX)
                begin
                    i_next     = '0;
                    state_next = grl_pkg::ST_IDLE;
                end
                else
                begin
                    i_next = i_reg + RB'(1);
                end
            end
            grl_pkg::ST_IDLE:
            begin
                if (accept && operation == grl_pkg::OP_LOOKUP)
                begin
                    state_next = grl_pkg::ST_LOOK;
                end
                else if (accept)
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        stop_we    = 1'b1;
                        count_next = count_reg + CW'(1);
                        if (count_reg == '0)
                        begin
                            first_nz_next = (pos_sat != 17'd0);
                        end
                    end
                    if (last_stop)
                    begin
                        if (ovf_reg || full)
                        begin
                            status_next = grl_pkg::STATUS_OVERFLOW;
                            count_next  = '0;
                            ovf_next    = 1'b0;
                            state_next  = grl_pkg::ST_STAT;
                        end
                        else
                        begin
                            status_next = grl_pkg::STATUS_OK;
                            state_next  = grl_pkg::ST_FETCH0;
                        end
                    end
                end
            end
            grl_pkg::ST_LOOK:
            begin
                done       = 1'b1;
                ramp_color = mem_rdata;
                state_next = grl_pkg::ST_IDLE;
            end
            grl_pkg::ST_STAT:
            begin
                done       = 1'b1;
                status     = status_reg;
                state_next = grl_pkg::ST_IDLE;
            end
            grl_pkg::ST_FETCH0:
            begin
                fetch_sel    = '0;
                cur_idx_next = stop_idx_mem[fetch_sel];
                cur_col_next = stop_col_mem[fetch_sel];
                c_next       = '0;
                i_next       = '0;
                state_next   = first_nz_reg ? grl_pkg::ST_PAD0 : grl_pkg::ST_SEG;
            end
            grl_pkg::ST_PAD0:
            begin
                mem_we = 1'b1;
                if (i_reg == cur_idx_reg)
                begin
                    state_next = grl_pkg::ST_SEG;
                end
                else
                begin
                    i_next = i_reg + RB'(1);
                end
            end
            grl_pkg::ST_SEG:
            begin
                if ((CW+1)'(c_reg) + (CW+1)'(1) < (CW+1)'(count_reg))
                begin
                    nxt_idx_next = stop_idx_mem[fetch_sel];
                    nxt_col_next = stop_col_mem[fetch_sel];
                    state_next   = grl_pkg::ST_SEGCHK;
                end
                else
                begin
                    i_next     = cur_idx_reg;
                    state_next = grl_pkg::ST_TAIL;
                end
            end
            grl_pkg::ST_SEGCHK:
            begin
                if (nxt_idx_reg > cur_idx_reg)
                begin
                    diff_next  = nxt_idx_reg - cur_idx_reg;
                    i_next     = cur_idx_reg;
                    state_next = grl_pkg::ST_DIVINIT;
                end
                else
                begin
                    state_next = grl_pkg::ST_ADV;
                end
            end
            grl_pkg::ST_DIVINIT:
            begin
                rem_next   = {k, 8'd0} - (RB+8)'(k);
                dsh_next   = {1'b0, diff_reg, 7'd0};
                q_next     = '0;
                bit_next   = 3'd7;
                state_next = grl_pkg::ST_DIV;
            end
            grl_pkg::ST_DIV:
            begin
                if (rem_reg >= dsh_reg)
                begin
                    rem_next = rem_reg - dsh_reg;
                    q_next   = q_reg | (8'd1 << bit_reg);
                end
                dsh_next = dsh_reg >> 1;
                if (bit_reg == 3'd0)
                begin
                    ch_next    = 2'd0;
                    state_next = grl_pkg::ST_BLEND;
                end
                else
                begin
                    bit_next = bit_reg - 3'd1;
                end
            end
            grl_pkg::ST_BLEND:
            begin
                blend_next = {ch_res, blend_reg[31:8]};
                if (ch_reg == 2'd3)
                begin
                    state_next = grl_pkg::ST_WRITE;
                end
                else
                begin
                    ch_next = ch_reg + 2'd1;
                end
            end
            grl_pkg::ST_WRITE:
            begin
                mem_we    = 1'b1;
                mem_wdata = blend_reg;
                if (i_reg == nxt_idx_reg)
                begin
                    state_next = grl_pkg::ST_ADV;
                end
                else
                begin
                    i_next     = i_reg + RB'(1);
                    state_next = grl_pkg::ST_DIVINIT;
                end
            end
            grl_pkg::ST_ADV:
            begin
                cur_idx_next = nxt_idx_reg;
                cur_col_next = nxt_col_reg;
                c_next       = c_reg + CW'(1);
                state_next   = grl_pkg::ST_SEG;
            end
            grl_pkg::ST_TAIL:
            begin
                mem_we = 1'b1;
                if (i_reg == RAMP_MAX)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = grl_pkg::ST_STAT;
                end
                else
                begin
                    i_next = i_reg + RB'(1);
                end
            end
            default:
            begin
                state_next = grl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= grl_pkg::ST_CLEAR;
            mode_reg     <= grl_pkg::MODE_PAD;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            first_nz_reg <= 1'b0;
            status_reg   <= grl_pkg::STATUS_OK;
            c_reg        <= '0;
            i_reg        <= '0;
            bit_reg      <= '0;
            ch_reg       <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            first_nz_reg <= first_nz_next;
            status_reg   <= status_next;
            c_reg        <= c_next;
            i_reg        <= i_next;
            bit_reg      <= bit_next;
            ch_reg       <= ch_next;
            if (psel && penable && pwrite && pready && paddr == grl_pkg::REG_ADDR_MODE)
            begin
                mode_reg <= pwdata[1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_idx_reg <= cur_idx_next;
        cur_col_reg <= cur_col_next;
        nxt_idx_reg <= nxt_idx_next;
        nxt_col_reg <= nxt_col_next;
        diff_reg    <= diff_next;
        rem_reg     <= rem_next;
        dsh_reg     <= dsh_next;
        q_reg       <= q_next;
        blend_reg   <= blend_next;
        if (stop_we)
        begin
            stop_idx_mem[count_reg] <= new_idx;
            stop_col_mem[count_reg] <= stop_color;
        end
    end

endmodule

[design/grl_checker.sv]
`include "gradient_ramp_lookup_macros.svh"

module grl_assertions (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic operation,
    input logic done,
    input logic status,
    input logic pready
);

    logic lookup_xfer;

    assign lookup_xfer = start && !busy && operation == grl_pkg::OP_LOOKUP;

    // a lookup transfer answers in the next cycle with ok status
    `GRL_ASSERT_NEXT(a_lookup_answer, lookup_xfer, done && status == grl_pkg::STATUS_OK)

    // no new transfer can be taken while a result shows
    `GRL_ASSERT_NOW(a_done_busy, done, busy)

    // a result shows for one cycle only
    `GRL_ASSERT_NEXT(a_done_single, done, !done)

    // the configuration port never stalls
    `GRL_ASSERT_NOW(a_pready_high, 1'b1, pready)

endmodule

bind gradient_ramp_lookup grl_assertions u_grl_assertions (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .operation(operation),
    .done     (done),
    .status   (status),
    .pready   (pready)
);
